// ===== hdl/stip_pkg.sv =====
package stip_pkg;

	// result form codes
	typedef enum logic [1:0] {
		FORM_DEC   = 2'd0,
		FORM_HEX   = 2'd1,
		FORM_CHAR  = 2'd2,
		FORM_EMPTY = 2'd3
	} form_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_HIGH   = 8'h80;
	localparam logic [3:0] HEX_ALPHA = 4'd10;

endpackage

// ===== hdl/stip_in_if.sv =====
interface stip_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

// ===== hdl/stip_out_if.sv =====
interface stip_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	stip_pkg::form_t    form;

	modport source (output valid, output value, output form, input ready);
	modport sink (input valid, input value, input form, output ready);
endinterface

// ===== hdl/string_to_int_parser.sv =====
// Parses a byte stream into one signed 32-bit integer per string: leading whitespace
// (bytes 1..32 and 128..255) is skipped, an optional sign is taken, then a 0x/0X hex
// number, a quoted char or a decimal number; the result appears on the byte marked last.
// One byte is taken every cycle while the input is not stalled. A byte passes an input
// register, the parser state is updated from it and, for a last byte, a result is loaded
// into the output register. Input stalls only while a last byte waits in the input
// register and the output register still holds a result that has not been taken.
module string_to_int_parser (
	input logic        clk,
	input logic        arst_n,
	stip_in_if.sink    text,
	stip_out_if.source result
);

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_SIGNED,
		PH_ZERO,
		PH_HEX,
		PH_DEC,
		PH_QUOTE,
		PH_DONE
	} phase_t;

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// parser state
	phase_t          phase_q, phase_d;
	logic [31:0]     accum_q, accum_d;
	logic            neg_q, neg_d;
	stip_pkg::form_t form_q, form_d;

	// output register
	logic               out_valid_q;
	logic signed [31:0] value_q;
	stip_pkg::form_t    out_form_q;

	logic        out_free;
	logic        s1_go;
	logic        is_dec;
	logic [3:0]  dec_val;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [31:0] accum_x10;
	logic [31:0] accum_x16;

	assign out_free   = !out_valid_q || result.ready;
	assign s1_go      = valid_s1 && (!last_s1 || out_free);
	assign text.ready = !valid_s1 || s1_go;

	assign result.valid = out_valid_q;
	assign result.value = value_q;
	assign result.form  = out_form_q;

	always_comb begin
		is_dec  = (ch_s1 >= stip_pkg::CH_ZERO) && (ch_s1 <= stip_pkg::CH_NINE);
		dec_val = 4'(ch_s1 - stip_pkg::CH_ZERO);
		hex_ok  = 1'b1;
		if (is_dec) begin
			hex_val = dec_val;
		end else if (ch_s1 >= stip_pkg::CH_LOW_A && ch_s1 <= stip_pkg::CH_LOW_F) begin
			hex_val = 4'(ch_s1 - stip_pkg::CH_LOW_A) + stip_pkg::HEX_ALPHA;
		end else if (ch_s1 >= stip_pkg::CH_UP_A && ch_s1 <= stip_pkg::CH_UP_F) begin
			hex_val = 4'(ch_s1 - stip_pkg::CH_UP_A) + stip_pkg::HEX_ALPHA;
		end else begin
			hex_val = '0;
			hex_ok  = 1'b0;
		end
		// times ten as two shifted copies
		accum_x10 = {accum_q[28:0], 3'b000} + {accum_q[30:0], 1'b0} + {28'd0, dec_val};
		accum_x16 = {accum_q[27:0], hex_val};
	end

	always_comb begin
		phase_d = phase_q;
		accum_d = accum_q;
		neg_d   = neg_q;
		form_d  = form_q;
		case (phase_q)
			PH_SKIP, PH_SIGNED: begin
				if (phase_q == PH_SKIP && ch_s1 == stip_pkg::CH_NUL) begin
					phase_d = PH_DONE;
				end else if (phase_q == PH_SKIP
						&& (ch_s1 <= stip_pkg::CH_SPACE || ch_s1 >= stip_pkg::CH_HIGH)) begin
					phase_d = PH_SKIP;
				end else if (phase_q == PH_SKIP && ch_s1 == stip_pkg::CH_MINUS) begin
					neg_d   = 1'b1;
					form_d  = stip_pkg::FORM_DEC;
					phase_d = PH_SIGNED;
				end else if (phase_q == PH_SKIP && ch_s1 == stip_pkg::CH_PLUS) begin
					form_d  = stip_pkg::FORM_DEC;
					phase_d = PH_SIGNED;
				end else begin
					// start of the number body
					form_d = stip_pkg::FORM_DEC;
					if (ch_s1 == stip_pkg::CH_ZERO) begin
						phase_d = PH_ZERO;
					end else if (ch_s1 == stip_pkg::CH_QUOTE) begin
						form_d  = stip_pkg::FORM_CHAR;
						phase_d = PH_QUOTE;
					end else if (is_dec) begin
						accum_d = {28'd0, dec_val};
						phase_d = PH_DEC;
					end else begin
						phase_d = PH_DONE;
					end
				end
			end
			PH_ZERO: begin
				if (ch_s1 == stip_pkg::CH_LOW_X || ch_s1 == stip_pkg::CH_UP_X) begin
					form_d  = stip_pkg::FORM_HEX;
					phase_d = PH_HEX;
				end else if (is_dec) begin
					accum_d = {28'd0, dec_val};
					phase_d = PH_DEC;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_HEX: begin
				if (hex_ok) begin
					accum_d = accum_x16;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_DEC: begin
				if (is_dec) begin
					accum_d = accum_x10;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_QUOTE: begin
				accum_d = {{24{ch_s1[7]}}, ch_s1};
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			ch_s1   <= text.ch;
			last_s1 <= text.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			accum_q <= '0;
			neg_q   <= 1'b0;
			form_q  <= stip_pkg::FORM_EMPTY;
		end else if (s1_go) begin
			if (last_s1) begin
				phase_q <= PH_SKIP;
				accum_q <= '0;
				neg_q   <= 1'b0;
				form_q  <= stip_pkg::FORM_EMPTY;
			end else begin
				phase_q <= phase_d;
				accum_q <= accum_d;
				neg_q   <= neg_d;
				form_q  <= form_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			value_q    <= neg_d ? -$signed(accum_d) : $signed(accum_d);
			out_form_q <= form_d;
		end
	end

	// a finished string leaves the parser in its start state
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (phase_q == PH_SKIP && !neg_q
			&& form_q == stip_pkg::FORM_EMPTY && accum_q == '0))
	else $error("parser state not cleared after a result");

	// input stalls only behind a result that cannot leave
	assert property (@(posedge clk) disable iff (!arst_n)
		!text.ready |-> (valid_s1 && last_s1 && out_valid_q && !result.ready))
	else $error("input stalled without a pending result");

	// hex form is only ever seen while reading hex digits or after stopping
	assert property (@(posedge clk) disable iff (!arst_n)
		(form_q == stip_pkg::FORM_HEX) |-> (phase_q == PH_HEX || phase_q == PH_DONE))
	else $error("hex form outside hex phase");

	// a sign moves the parser out of whitespace skipping
	assert property (@(posedge clk) disable iff (!arst_n)
		neg_q |-> (phase_q != PH_SKIP && form_q != stip_pkg::FORM_EMPTY))
	else $error("sign recorded while still skipping whitespace");

endmodule

// ===== tb/number_checker.sv =====
`timescale 1ns / 100ps

module number_checker (
	input  logic clk,
	input  logic arst_n,
	stip_in_if   text,
	stip_out_if  result,
	output int   errors,
	output int   outstanding,
	output int   numbers_checked
);

	typedef enum logic [2:0] {
		SCAN_BLANKS,
		SCAN_SIGNED,
		SCAN_ZERO,
		SCAN_HEX,
		SCAN_DEC,
		SCAN_QUOTE,
		SCAN_STOPPED
	} scan_phase_t;

	typedef struct packed {
		logic [31:0]     value;
		stip_pkg::form_t form;
	} parsed_number_t;

	scan_phase_t     phase;
	logic [31:0]     accum;
	logic            negative;
	stip_pkg::form_t seen_form;
	parsed_number_t  owed_numbers[$];
	parsed_number_t  got_back;
	parsed_number_t  closing;

	function automatic bit is_digit(input logic [7:0] b);
		return b >= stip_pkg::CH_ZERO && b <= stip_pkg::CH_NINE;
	endfunction

	// 16 means not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [7:0] d;
		d = 8'd16;
		if (is_digit(b)) begin
			d = b - stip_pkg::CH_ZERO;
		end else if (b >= stip_pkg::CH_LOW_A && b <= stip_pkg::CH_LOW_F) begin
			d = b - stip_pkg::CH_LOW_A + stip_pkg::HEX_ALPHA;
		end else if (b >= stip_pkg::CH_UP_A && b <= stip_pkg::CH_UP_F) begin
			d = b - stip_pkg::CH_UP_A + stip_pkg::HEX_ALPHA;
		end
		return d[4:0];
	endfunction

	function automatic void clear_scan();
		phase = SCAN_BLANKS;
		accum = 32'd0;
		negative = 1'b0;
		seen_form = stip_pkg::FORM_EMPTY;
	endfunction

	function automatic void body_begin(input logic [7:0] b);
		seen_form = stip_pkg::FORM_DEC;
		if (b == stip_pkg::CH_ZERO) begin
			phase = SCAN_ZERO;
		end else if (b == stip_pkg::CH_QUOTE) begin
			seen_form = stip_pkg::FORM_CHAR;
			phase = SCAN_QUOTE;
		end else if (is_digit(b)) begin
			accum = {24'd0, b - stip_pkg::CH_ZERO};
			phase = SCAN_DEC;
		end else begin
			phase = SCAN_STOPPED;
		end
	endfunction

	function automatic void scan_byte(input logic [7:0] b);
		logic [4:0] h;
		h = hex_digit(b);
		case (phase)
			SCAN_BLANKS: begin
				if (b == stip_pkg::CH_NUL) begin
					phase = SCAN_STOPPED;
				end else if (b == stip_pkg::CH_MINUS || b == stip_pkg::CH_PLUS) begin
					negative = (b == stip_pkg::CH_MINUS);
					seen_form = stip_pkg::FORM_DEC;
					phase = SCAN_SIGNED;
				end else if (b > stip_pkg::CH_SPACE && b < stip_pkg::CH_HIGH) begin
					body_begin(b);
				end
			end
			SCAN_SIGNED: begin
				body_begin(b);
			end
			SCAN_ZERO: begin
				if (b == stip_pkg::CH_LOW_X || b == stip_pkg::CH_UP_X) begin
					seen_form = stip_pkg::FORM_HEX;
					phase = SCAN_HEX;
				end else if (is_digit(b)) begin
					accum = {24'd0, b - stip_pkg::CH_ZERO};
					phase = SCAN_DEC;
				end else begin
					phase = SCAN_STOPPED;
				end
			end
			SCAN_HEX: begin
				if (!h[4]) begin
					accum = {accum[27:0], h[3:0]};
				end else begin
					phase = SCAN_STOPPED;
				end
			end
			SCAN_DEC: begin
				if (is_digit(b)) begin
					accum = accum * 32'd10 + {28'd0, b[3:0]};
				end else begin
					phase = SCAN_STOPPED;
				end
			end
			SCAN_QUOTE: begin
				// char literal is a signed char
				accum = {{24{b[7]}}, b};
				phase = SCAN_STOPPED;
			end
			default: begin
				phase = SCAN_STOPPED;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			owed_numbers.delete();
			errors = 0;
			numbers_checked = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (owed_numbers.size() == 0) begin
					$error("unexpected result: value %0d form %0d", result.value, result.form);
					errors++;
				end else begin
					got_back = owed_numbers.pop_front();
					if (result.value !== got_back.value) begin
						$error("value: expected %0d, got %0d",
							$signed(got_back.value), result.value);
						errors++;
					end
					if (result.form !== got_back.form) begin
						$error("form: expected %0d, got %0d", got_back.form, result.form);
						errors++;
					end
					numbers_checked++;
				end
			end
			if (text.valid && text.ready) begin
				scan_byte(text.ch);
				if (text.last) begin
					closing.value = negative ? (32'd0 - accum) : accum;
					closing.form = seen_form;
					owed_numbers.push_back(closing);
					clear_scan();
				end
			end
		end
		outstanding = owed_numbers.size();
	end

endmodule

// ===== tb/tb_string_to_int_parser.sv =====
`timescale 1ns / 100ps

module tb_string_to_int_parser;

	localparam int TEXT_BYTES     = 1000;
	localparam int HOLD_OFF       = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk;
	logic arst_n;

	stip_in_if  text_bus ();
	stip_out_if result_bus ();

	int errors;
	int outstanding;
	int numbers_checked;
	int bytes_sent;
	int strings_sent;
	int burst_left;

	logic [7:0] text_bytes[$];

	string_to_int_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_bus),
		.result (result_bus)
	);

	number_checker number_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.text            (text_bus),
		.result          (result_bus),
		.errors          (errors),
		.outstanding     (outstanding),
		.numbers_checked (numbers_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic put_byte(input logic [7:0] b);
		text_bytes.push_back(b);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		int r;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3)
				burst_left = 60;
			gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		end
		if (gap > 0) begin
			text_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_bus.valid <= 1'b1;
		text_bus.ch <= b;
		text_bus.last <= fin;
		@(posedge clk);
		while (!text_bus.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_bytes.size(); i++)
			send_byte(text_bytes[i], i == text_bytes.size() - 1);
		text_bytes.delete();
		strings_sent++;
	endtask

	task automatic put_blank();
		logic [7:0] b;
		b = 8'($urandom_range(0, 1) ? $urandom_range(1, 32) : $urandom_range(128, 255));
		put_byte(b);
	endtask

	task automatic put_junk(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			put_byte(b);
		end
	endtask

	task automatic put_hex_digit();
		int v;
		logic [7:0] b;
		v = $urandom_range(0, 15);
		if (v < 10)
			b = stip_pkg::CH_ZERO + 8'(v);
		else
			b = ($urandom_range(0, 1) ? stip_pkg::CH_LOW_A : stip_pkg::CH_UP_A) + 8'(v - 10);
		put_byte(b);
	endtask

	// mostly well-formed numbers with random content, the rest noise
	task automatic build_random_text();
		int kind;
		int n;
		int sgn;
		logic [7:0] b;
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			put_junk($urandom_range(1, 6));
		end else begin
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) put_blank();
			sgn = $urandom_range(0, 2);
			if (sgn == 1)
				put_byte(stip_pkg::CH_MINUS);
			else if (sgn == 2)
				put_byte(stip_pkg::CH_PLUS);
			if (kind < 4) begin
				// long runs wrap past 32 bits
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 9);
				repeat (n) begin
					b = 8'($urandom_range(stip_pkg::CH_ZERO, stip_pkg::CH_NINE));
					put_byte(b);
				end
			end else if (kind < 7) begin
				put_byte(stip_pkg::CH_ZERO);
				put_byte($urandom_range(0, 1) ? stip_pkg::CH_LOW_X : stip_pkg::CH_UP_X);
				n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
				repeat (n) put_hex_digit();
			end else begin
				put_byte(stip_pkg::CH_QUOTE);
				if ($urandom_range(0, 9) != 0)
					put_junk(1);
			end
			if ($urandom_range(0, 3) == 0)
				put_junk($urandom_range(1, 3));
		end
	endtask

	task automatic run_directed();
		put_byte(8'hff); put_byte(8'h01); put_byte(stip_pkg::CH_MINUS);
		put_byte(stip_pkg::CH_ZERO); put_byte(stip_pkg::CH_LOW_X); put_byte(stip_pkg::CH_UP_F);
		send_text();
		// whitespace after the sign stops parsing
		put_byte(stip_pkg::CH_PLUS); put_byte(stip_pkg::CH_SPACE); send_text();
		put_byte(stip_pkg::CH_MINUS); send_text();
		put_byte(stip_pkg::CH_ZERO); put_byte(stip_pkg::CH_ZERO + 8'd7); send_text();
		// prefix with no digits
		put_byte(stip_pkg::CH_ZERO); put_byte(stip_pkg::CH_UP_X); send_text();
		put_byte(stip_pkg::CH_QUOTE); send_text();
		put_byte(stip_pkg::CH_QUOTE); put_byte(stip_pkg::CH_HIGH);
		put_byte(stip_pkg::CH_LOW_X + 8'd2); send_text();
		put_byte(stip_pkg::CH_QUOTE); put_byte(stip_pkg::CH_NUL); send_text();
		put_byte(stip_pkg::CH_NUL); send_text();
		put_byte(stip_pkg::CH_SPACE); send_text();
		// bytes after the stop are ignored
		put_byte(stip_pkg::CH_NINE); put_byte(stip_pkg::CH_LOW_A);
		put_byte(stip_pkg::CH_ZERO + 8'd5); send_text();
	endtask

	initial begin : stimulus
		text_bus.valid <= 1'b0;
		text_bus.ch <= stip_pkg::CH_NUL;
		text_bus.last <= 1'b0;
		arst_n <= 1'b0;
		bytes_sent = 0;
		strings_sent = 0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (bytes_sent < TEXT_BYTES) begin
			build_random_text();
			send_text();
		end
		text_bus.valid <= 1'b0;
		// let the checker take in the final request before looking at what is owed
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("tb: %0d strings in %0d bytes: decimal, hex, char literal, blank and malformed",
			strings_sent, bytes_sent);
		$display("tb: %0d parsed numbers compared, %0d mismatches", numbers_checked, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : drain
		int n;
		bit squeezed;
		squeezed = 1'b0;
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!squeezed && numbers_checked >= 30) begin
				// long hold-off so the parser backs up and stalls its input
				squeezed = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
				result_bus.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = ($urandom_range(0, 19) == 0) ? 100 : $urandom_range(1, 8);
				result_bus.ready <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((text_bus.valid && text_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule
